### src/mbfs_pkg.sv
// Shared constants, codes and control types of the motion blur frame scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mbfs_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int PHASE_W       = FRACTION_BITS + 4;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int WHOLE_W       = PHASE_W - FRACTION_BITS;

	localparam int STEP_W     = 19;
	localparam int EXPO_W     = 17;
	localparam int RECIP_W    = 25;
	localparam int WEIGHT_W   = 17;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;

	localparam int RLO_W  = 13;
	localparam int RHI_W  = RECIP_W - RLO_W;
	localparam int PLO_W  = FRAC_W + RLO_W;
	localparam int PHI_W  = FRAC_W + RHI_W;
	localparam int PROD_W = FRAC_W + RECIP_W;
	localparam int WSH_W  = PROD_W - FRACTION_BITS;

	localparam int MAX_EXTRA = 7;
	localparam int EXTRA_W   = 3;

	localparam logic [FRAC_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(2048);
	localparam logic [EXPO_W-1:0]  EXPO_RESET  = EXPO_W'(32768);
	localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(131072);

	typedef enum logic [CMD_W-1:0] {
		CMD_ACCUM = 2'd0,
		CMD_COPY  = 2'd1,
		CMD_EMIT  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLUR_ENABLE = 2'd0,
		CFG_PHASE_STEP  = 2'd1,
		CFG_EXPOSURE    = 2'd2,
		CFG_EXPO_RECIP  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic restart;
		logic mark_seen;
		logic eval;
		logic load_diff;
		logic diff_tail;
		logic mul_lo;
		logic mul_hi;
		logic load_res;
		cmd_t res_cmd;
		logic res_last;
	} dp_cmd_t;

	typedef struct packed {
		logic               seen;
		logic               blur;
		logic               slot_free;
		logic               no_result;
		logic               closing;
		logic               tail;
		logic [EXTRA_W-1:0] extra;
	} dp_status_t;

endpackage
`default_nettype wire

### src/mbfs_if.sv
// Request channel interfaces: tick input, command output and register write port.
`timescale 1ns / 1ps
`default_nettype none
interface mbfs_tick_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mbfs_result_if;
	logic                         valid;
	logic                         ready;
	logic [mbfs_pkg::CMD_W-1:0]    command;
	logic [mbfs_pkg::WEIGHT_W-1:0] weight;
	logic                         last;
	modport source (output valid, output command, output weight, output last, input ready);
	modport sink (input valid, input command, input weight, input last, output ready);
endinterface

interface mbfs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mbfs_pkg::CFG_IDX_W-1:0]  index;
	logic [mbfs_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/motion_blur_frame_scheduler_unit.sv
// Top level of the motion blur frame scheduler: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
// Each tick request is taken only while the controller is idle. A restart and the first tick
// after a restart are absorbed in the accepting cycle with no result, and a blur tick whose
// phase stays within the unexposed part of the frame ends in the evaluation state with no
// result. Without blur a tick gives two results, a copy and an emit. With blur the controller
// evaluates the phase and then, for every weighted accumulate, forms the difference and passes
// it through the weight multiplier, which works on the reciprocal in a low and a high half.
// A closing tick gives up to seven extra emits and may end with a carry-over accumulate.
// A result waits in the output register while the sink holds ready low; the sequence then
// stalls until that register is free. Register writes are always accepted.
module motion_blur_frame_scheduler_unit (
	input  wire            clk,
	input  wire            arst_n,
	mbfs_tick_if.sink      tick,
	mbfs_result_if.source  result,
	mbfs_cfg_if.sink       cfg
);

	mbfs_pkg::dp_cmd_t     cmd;
	mbfs_pkg::dp_status_t  status;

	mbfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.status (status),
		.cmd    (cmd)
	);

	mbfs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.cfg    (cfg),
		.result (result)
	);

	// Only an accumulate request carries a weight.
	a_weight_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.command != mbfs_pkg::CMD_ACCUM) |-> result.weight == '0)
		else $error("non-accumulate request carries a weight");

	// Weights saturate at one.
	a_weight_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.weight <= mbfs_pkg::WEIGHT_W'(mbfs_pkg::ONE))
		else $error("weight above one");

	// A restart forgets the first tick.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready && tick.restart |=> !status.seen)
		else $error("first-tick flag survives a restart");

endmodule
`default_nettype wire

### src/mbfs_datapath.sv
// Datapath: registers, phase accumulator, weight multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none
module mbfs_datapath (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire mbfs_pkg::dp_cmd_t    cmd,
	output mbfs_pkg::dp_status_t      status,
	mbfs_cfg_if.sink                  cfg,
	mbfs_result_if.source             result
);

	logic                                  blur_q;
	logic [mbfs_pkg::STEP_W-1:0]           step_q;
	logic [mbfs_pkg::EXPO_W-1:0]           expo_q;
	logic [mbfs_pkg::RECIP_W-1:0]          recip_q;
	logic [mbfs_pkg::FRAC_W-1:0]           phase_q;
	logic                                  seen_q;
	logic [mbfs_pkg::PHASE_W-1:0]          p_q;
	logic [mbfs_pkg::FRAC_W-1:0]           thr_q;
	logic [mbfs_pkg::FRAC_W-1:0]           start_q;
	logic [mbfs_pkg::FRAC_W-1:0]           diff_q;
	logic [mbfs_pkg::PLO_W-1:0]            pp_lo_q;
	logic [mbfs_pkg::PHI_W-1:0]            pp_hi_q;
	logic                                  out_valid_q;
	logic [mbfs_pkg::CMD_W-1:0]            out_cmd_q;
	logic [mbfs_pkg::WEIGHT_W-1:0]         out_weight_q;
	logic                                  out_last_q;

	logic [mbfs_pkg::FRAC_W-1:0]           expo_clip;
	logic [mbfs_pkg::FRAC_W-1:0]           thr;
	logic [mbfs_pkg::FRAC_W-1:0]           phase_ext;
	logic [mbfs_pkg::PHASE_W-1:0]          p_sum;
	logic [mbfs_pkg::WHOLE_W-1:0]          whole;
	logic [mbfs_pkg::FRAC_W-1:0]           diff;
	logic [mbfs_pkg::PROD_W-1:0]           prod;
	logic [mbfs_pkg::WSH_W-1:0]            wsh;
	logic [mbfs_pkg::WEIGHT_W-1:0]         wsat;

	assign expo_clip = (mbfs_pkg::FRAC_W'(expo_q) > mbfs_pkg::ONE) ?
		mbfs_pkg::ONE : mbfs_pkg::FRAC_W'(expo_q);
	assign thr       = mbfs_pkg::ONE - expo_clip;
	assign phase_ext = phase_q;
	assign p_sum     = mbfs_pkg::PHASE_W'(phase_q) + mbfs_pkg::PHASE_W'(step_q);
	assign whole     = p_q[mbfs_pkg::PHASE_W-1:mbfs_pkg::FRACTION_BITS];

	always_comb begin
		if (cmd.diff_tail) begin
			diff = mbfs_pkg::FRAC_W'(p_q[mbfs_pkg::FRACTION_BITS-1:0]) - thr_q;
		end else if (status.closing) begin
			diff = mbfs_pkg::ONE - start_q;
		end else begin
			diff = mbfs_pkg::FRAC_W'(p_q) - start_q;
		end
	end

	assign prod = mbfs_pkg::PROD_W'(pp_lo_q) + (mbfs_pkg::PROD_W'(pp_hi_q) << mbfs_pkg::RLO_W);
	assign wsh  = prod[mbfs_pkg::PROD_W-1:mbfs_pkg::FRACTION_BITS];
	assign wsat = (wsh > mbfs_pkg::WSH_W'(mbfs_pkg::ONE)) ?
		mbfs_pkg::WEIGHT_W'(mbfs_pkg::ONE) : mbfs_pkg::WEIGHT_W'(wsh);

	always_comb begin
		status.seen      = seen_q;
		status.blur      = blur_q;
		status.slot_free = !out_valid_q || result.ready;
		status.closing   = |whole;
		status.no_result = p_q <= mbfs_pkg::PHASE_W'(thr_q);
		status.tail      = mbfs_pkg::FRAC_W'(p_q[mbfs_pkg::FRACTION_BITS-1:0]) > thr_q;
		if (whole == '0) begin
			status.extra = '0;
		end else if (whole > mbfs_pkg::WHOLE_W'(mbfs_pkg::MAX_EXTRA)) begin
			status.extra = mbfs_pkg::EXTRA_W'(mbfs_pkg::MAX_EXTRA);
		end else begin
			status.extra = mbfs_pkg::EXTRA_W'(whole - mbfs_pkg::WHOLE_W'(1));
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_q  <= 1'b0;
			step_q  <= mbfs_pkg::STEP_RESET;
			expo_q  <= mbfs_pkg::EXPO_RESET;
			recip_q <= mbfs_pkg::RECIP_RESET;
		end else if (cfg.valid) begin
			unique case (mbfs_pkg::cfg_idx_t'(cfg.index))
				mbfs_pkg::CFG_BLUR_ENABLE: blur_q  <= cfg.data[0];
				mbfs_pkg::CFG_PHASE_STEP:  step_q  <= cfg.data[mbfs_pkg::STEP_W-1:0];
				mbfs_pkg::CFG_EXPOSURE:    expo_q  <= cfg.data[mbfs_pkg::EXPO_W-1:0];
				mbfs_pkg::CFG_EXPO_RECIP:  recip_q <= cfg.data[mbfs_pkg::RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	// With zero exposure the phase may rest at exactly one without closing a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			seen_q  <= 1'b0;
		end else if (cmd.restart) begin
			phase_q <= '0;
			seen_q  <= 1'b0;
		end else begin
			if (cmd.mark_seen) begin
				seen_q <= 1'b1;
			end
			if (cmd.eval) begin
				phase_q <= (p_sum <= mbfs_pkg::PHASE_W'(thr)) ? mbfs_pkg::FRAC_W'(p_sum) :
					mbfs_pkg::FRAC_W'(p_sum[mbfs_pkg::FRACTION_BITS-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			p_q     <= p_sum;
			thr_q   <= thr;
			start_q <= (phase_ext > thr) ? phase_ext : thr;
		end
		if (cmd.load_diff) begin
			diff_q <= diff;
		end
		if (cmd.mul_lo) begin
			pp_lo_q <= mbfs_pkg::PLO_W'(diff_q) * mbfs_pkg::PLO_W'(recip_q[mbfs_pkg::RLO_W-1:0]);
		end
		if (cmd.mul_hi) begin
			pp_hi_q <= mbfs_pkg::PHI_W'(diff_q) *
				mbfs_pkg::PHI_W'(recip_q[mbfs_pkg::RECIP_W-1:mbfs_pkg::RLO_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			out_cmd_q    <= cmd.res_cmd;
			out_weight_q <= (cmd.res_cmd == mbfs_pkg::CMD_ACCUM) ? wsat : '0;
			out_last_q   <= cmd.res_last;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.command = out_cmd_q;
	assign result.weight  = out_weight_q;
	assign result.last    = out_last_q;

endmodule
`default_nettype wire

### src/mbfs_ctrl.sv
// Controller: sequences the commands that one tick gives.
`timescale 1ns / 1ps
`default_nettype none
module mbfs_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	mbfs_tick_if.sink                  tick,
	input  wire mbfs_pkg::dp_status_t  status,
	output mbfs_pkg::dp_cmd_t          cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_COPY,
		S_PASS_EMIT,
		S_EVAL,
		S_DIFF,
		S_MUL_LO,
		S_MUL_HI,
		S_ACCUM,
		S_EMIT,
		S_EXTRA,
		S_CLEAR
	} state_t;

	state_t                        state_q;
	logic                          tail_q;
	logic [mbfs_pkg::EXTRA_W-1:0]  extra_q;

	always_comb begin
		cmd          = '0;
		cmd.res_cmd  = mbfs_pkg::CMD_ACCUM;
		cmd.diff_tail = tail_q;
		tick.ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				tick.ready = 1'b1;
				if (tick.valid) begin
					if (tick.restart) begin
						cmd.restart = 1'b1;
					end else if (!status.seen) begin
						cmd.mark_seen = 1'b1;
					end else if (status.blur) begin
						cmd.eval = 1'b1;
					end
				end
			end
			S_COPY: begin
				cmd.load_res = status.slot_free;
				cmd.res_cmd  = mbfs_pkg::CMD_COPY;
			end
			S_PASS_EMIT: begin
				cmd.load_res = status.slot_free;
				cmd.res_cmd  = mbfs_pkg::CMD_EMIT;
				cmd.res_last = 1'b1;
			end
			S_EVAL: ;
			S_DIFF:   cmd.load_diff = 1'b1;
			S_MUL_LO: cmd.mul_lo = 1'b1;
			S_MUL_HI: cmd.mul_hi = 1'b1;
			S_ACCUM: begin
				cmd.load_res = status.slot_free;
				cmd.res_cmd  = mbfs_pkg::CMD_ACCUM;
				cmd.res_last = tail_q || !status.closing;
			end
			S_EMIT, S_EXTRA: begin
				cmd.load_res = status.slot_free;
				cmd.res_cmd  = mbfs_pkg::CMD_EMIT;
			end
			S_CLEAR: begin
				cmd.load_res = status.slot_free;
				cmd.res_cmd  = mbfs_pkg::CMD_CLEAR;
				cmd.res_last = !status.tail;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tail_q  <= 1'b0;
			extra_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					tail_q <= 1'b0;
					if (tick.valid && !tick.restart && status.seen) begin
						state_q <= status.blur ? S_EVAL : S_COPY;
					end
				end
				S_COPY: begin
					if (status.slot_free) begin
						state_q <= S_PASS_EMIT;
					end
				end
				S_PASS_EMIT: begin
					if (status.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EVAL:   state_q <= status.no_result ? S_IDLE : S_DIFF;
				S_DIFF:   state_q <= S_MUL_LO;
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ACCUM;
				S_ACCUM: begin
					if (status.slot_free) begin
						state_q <= (tail_q || !status.closing) ? S_IDLE : S_EMIT;
					end
				end
				S_EMIT: begin
					if (status.slot_free) begin
						extra_q <= status.extra;
						state_q <= (status.extra != '0) ? S_EXTRA : S_CLEAR;
					end
				end
				S_EXTRA: begin
					if (status.slot_free) begin
						extra_q <= extra_q - mbfs_pkg::EXTRA_W'(1);
						if (extra_q == mbfs_pkg::EXTRA_W'(1)) begin
							state_q <= S_CLEAR;
						end
					end
				end
				S_CLEAR: begin
					if (status.slot_free) begin
						if (status.tail) begin
							tail_q  <= 1'b1;
							state_q <= S_DIFF;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### bench/motion_blur_frame_scheduler_unit_tb.sv
// Self-checking bench for the motion blur frame scheduler, with a predictor of the command stream.
`timescale 1ns / 1ps
module motion_blur_frame_scheduler_unit_tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int GAP_PERCENT   = 24;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_TICKS   = 14;

	typedef struct {
		mbfs_pkg::cmd_t                command;
		logic [mbfs_pkg::WEIGHT_W-1:0] weight;
		logic                          last;
	} frame_cmd_t;

	logic clk;
	logic arst_n;

	mbfs_tick_if   tick_ch ();
	mbfs_result_if result_ch ();
	mbfs_cfg_if    cfg_ch ();

	motion_blur_frame_scheduler_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic                          blur_on   = 1'b0;
	logic [mbfs_pkg::STEP_W-1:0]   step_cfg  = mbfs_pkg::STEP_RESET;
	logic [mbfs_pkg::EXPO_W-1:0]   expo_cfg  = mbfs_pkg::EXPO_RESET;
	logic [mbfs_pkg::RECIP_W-1:0]  recip_cfg = mbfs_pkg::RECIP_RESET;
	logic [mbfs_pkg::PHASE_W-1:0]  phase_acc = '0;
	logic                          seen_tick = 1'b0;

	frame_cmd_t pending_cmds[$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;
	bit         tick_gaps      = 1'b1;
	bit         ready_gaps     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(negedge clk) begin
		result_ch.ready <= !ready_gaps || ($urandom_range(99) >= GAP_PERCENT);
	end

	function automatic logic [mbfs_pkg::WEIGHT_W-1:0] blur_weight(
			input logic [mbfs_pkg::PHASE_W-1:0] diff);
		logic [63:0] prod;
		prod = (64'(diff) * 64'(recip_cfg)) >> mbfs_pkg::FRACTION_BITS;
		if (prod > 64'(mbfs_pkg::ONE))
			return mbfs_pkg::ONE;
		return prod[mbfs_pkg::WEIGHT_W-1:0];
	endfunction

	task automatic add_cmd(input mbfs_pkg::cmd_t command,
			input logic [mbfs_pkg::WEIGHT_W-1:0] weight);
		frame_cmd_t entry;
		entry.command = command;
		entry.weight  = weight;
		entry.last    = 1'b0;
		pending_cmds.push_back(entry);
	endtask

	task automatic schedule_tick(input logic restart);
		logic [mbfs_pkg::PHASE_W-1:0] thr;
		logic [mbfs_pkg::PHASE_W-1:0] start;
		logic [mbfs_pkg::PHASE_W-1:0] p;
		logic [mbfs_pkg::PHASE_W-1:0] rem;
		logic [mbfs_pkg::EXPO_W-1:0]  expo_eff;
		int                           first_idx;
		int                           extra;
		first_idx = pending_cmds.size();
		if (restart) begin
			phase_acc = '0;
			seen_tick = 1'b0;
		end else if (!seen_tick) begin
			seen_tick = 1'b1;
		end else if (!blur_on) begin
			add_cmd(mbfs_pkg::CMD_COPY, '0);
			add_cmd(mbfs_pkg::CMD_EMIT, '0);
		end else begin
			expo_eff = (expo_cfg > mbfs_pkg::ONE) ? mbfs_pkg::ONE : expo_cfg;
			thr      = mbfs_pkg::PHASE_W'(mbfs_pkg::ONE) - mbfs_pkg::PHASE_W'(expo_eff);
			start    = (phase_acc > thr) ? phase_acc : thr;
			p        = phase_acc + mbfs_pkg::PHASE_W'(step_cfg);
			if (p <= thr) begin
				phase_acc = p;
			end else if (p < mbfs_pkg::PHASE_W'(mbfs_pkg::ONE)) begin
				add_cmd(mbfs_pkg::CMD_ACCUM, blur_weight(p - start));
				phase_acc = p;
			end else begin
				add_cmd(mbfs_pkg::CMD_ACCUM,
					blur_weight(mbfs_pkg::PHASE_W'(mbfs_pkg::ONE) - start));
				add_cmd(mbfs_pkg::CMD_EMIT, '0);
				rem   = p - mbfs_pkg::PHASE_W'(mbfs_pkg::ONE);
				extra = int'(rem >> mbfs_pkg::FRACTION_BITS);
				if (extra > mbfs_pkg::MAX_EXTRA)
					extra = mbfs_pkg::MAX_EXTRA;
				repeat (extra) add_cmd(mbfs_pkg::CMD_EMIT, '0);
				rem[mbfs_pkg::PHASE_W-1:mbfs_pkg::FRACTION_BITS] = '0;
				add_cmd(mbfs_pkg::CMD_CLEAR, '0);
				phase_acc = rem;
				if (rem > thr)
					add_cmd(mbfs_pkg::CMD_ACCUM, blur_weight(rem - thr));
			end
		end
		if (pending_cmds.size() > first_idx)
			pending_cmds[pending_cmds.size() - 1].last = 1'b1;
	endtask

	// Results are checked before the tick of the same edge is predicted, since a result
	// can never stem from a request accepted at that very edge.
	always @(posedge clk) begin : monitor
		frame_cmd_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_cmds.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("unexpected result: command %0d weight %0d last %0d",
							result_ch.command, result_ch.weight, result_ch.last);
					mismatch_count++;
				end else begin
					want = pending_cmds.pop_front();
					if (result_ch.command !== want.command || result_ch.weight !== want.weight ||
							result_ch.last !== want.last) begin
						if (mismatch_count < MAX_REPORTS)
							$display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								want.command, want.weight, want.last,
								result_ch.command, result_ch.weight, result_ch.last);
						mismatch_count++;
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					mbfs_pkg::CFG_BLUR_ENABLE: blur_on   = cfg_ch.data[0];
					mbfs_pkg::CFG_PHASE_STEP:  step_cfg  = cfg_ch.data[mbfs_pkg::STEP_W-1:0];
					mbfs_pkg::CFG_EXPOSURE:    expo_cfg  = cfg_ch.data[mbfs_pkg::EXPO_W-1:0];
					mbfs_pkg::CFG_EXPO_RECIP:  recip_cfg = cfg_ch.data[mbfs_pkg::RECIP_W-1:0];
					default: ;
				endcase
			end
			if (tick_ch.valid && tick_ch.ready)
				schedule_tick(tick_ch.restart);
		end
	end

	task automatic send_tick(input logic restart);
		while (tick_gaps && $urandom_range(99) < GAP_PERCENT) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid   <= 1'b1;
		tick_ch.restart <= restart;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input mbfs_pkg::cfg_idx_t index,
			input logic [mbfs_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic await_idle();
		tick_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_config(input logic blur, input logic [mbfs_pkg::STEP_W-1:0] step,
			input logic [mbfs_pkg::EXPO_W-1:0] expo,
			input logic [mbfs_pkg::RECIP_W-1:0] recip);
		await_idle();
		write_reg(mbfs_pkg::CFG_BLUR_ENABLE, mbfs_pkg::CFG_DATA_W'(blur));
		write_reg(mbfs_pkg::CFG_PHASE_STEP, mbfs_pkg::CFG_DATA_W'(step));
		write_reg(mbfs_pkg::CFG_EXPOSURE, mbfs_pkg::CFG_DATA_W'(expo));
		write_reg(mbfs_pkg::CFG_EXPO_RECIP, mbfs_pkg::CFG_DATA_W'(recip));
	endtask

	task automatic test_reset_defaults();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
	endtask

	task automatic test_blur_window();
		load_config(1'b1, 19'd20000, 17'd32768, 25'd131072);
		send_tick(1'b1);
		repeat (6) send_tick(1'b0);
		await_idle();
		write_reg(mbfs_pkg::CFG_BLUR_ENABLE, '0);
		send_tick(1'b0);
		await_idle();
		write_reg(mbfs_pkg::CFG_BLUR_ENABLE, mbfs_pkg::CFG_DATA_W'(1));
		send_tick(1'b0);
	endtask

	task automatic test_extremes();
		load_config(1'b1, 19'd524287, 17'd65536, 25'd65536);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		load_config(1'b1, 19'd70000, 17'd0, 25'd16777216);
		repeat (3) send_tick(1'b0);
		// With no exposure the phase comes to rest at exactly one before the frame closes.
		load_config(1'b1, 19'd32768, 17'd0, 25'd16777216);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		load_config(1'b1, 19'd40000, 17'd131071, 25'd16777216);
		repeat (3) send_tick(1'b0);
		load_config(1'b1, 19'd1, 17'd256, 25'd16777216);
		repeat (2) send_tick(1'b0);
		send_tick(1'b1);
	endtask

	task automatic test_random_ticks();
		logic [mbfs_pkg::STEP_W-1:0]  step;
		logic [mbfs_pkg::EXPO_W-1:0]  expo;
		logic [mbfs_pkg::RECIP_W-1:0] recip;
		logic                         blur;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(3))
				0: step = mbfs_pkg::STEP_W'($urandom_range(8191, 1));
				1: step = mbfs_pkg::STEP_W'($urandom_range(65535, 8192));
				2: step = mbfs_pkg::STEP_W'($urandom_range(524287, 65536));
				default: step = mbfs_pkg::STEP_W'($urandom_range(524287, 1));
			endcase
			case ($urandom_range(9))
				0: expo = '0;
				1: expo = mbfs_pkg::EXPO_W'($urandom_range(131071, 65537));
				default: expo = mbfs_pkg::EXPO_W'($urandom_range(65536, 256));
			endcase
			if ($urandom_range(1) == 0)
				recip = mbfs_pkg::RECIP_W'($urandom_range(16777216, 65536));
			else if (expo == '0 || expo < 256)
				recip = mbfs_pkg::RECIP_W'(16777216);
			else if (expo > mbfs_pkg::ONE)
				recip = mbfs_pkg::RECIP_W'(65536);
			else
				recip = mbfs_pkg::RECIP_W'(64'h1_0000_0000 / expo);
			blur = ($urandom_range(3) != 0);
			tick_gaps  = (ph != 2);
			ready_gaps = (ph != 2);
			load_config(blur, step, expo, recip);
			write_reg(mbfs_pkg::CFG_BLUR_ENABLE, {24'($urandom), blur});
			for (int i = 0; i < PHASE_TICKS; i++)
				send_tick($urandom_range(99) < 8);
		end
		tick_gaps  = 1'b1;
		ready_gaps = 1'b1;
	endtask

	initial begin
		tick_ch.valid   = 1'b0;
		tick_ch.restart = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = mbfs_pkg::CFG_BLUR_ENABLE;
		cfg_ch.data     = '0;
		result_ch.ready = 1'b0;
		arst_n          = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_blur_window();
		test_extremes();
		test_random_ticks();
		await_idle();
		if (mismatch_count == 0 && pending_cmds.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
